[hdl/period_sorted_priority_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the period sorted priority table
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef PERIOD_SORTED_PRIORITY_TABLE_ASSERT_SVH
`define PERIOD_SORTED_PRIORITY_TABLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PSP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/psptab_pkg.sv]
// ----------------------------------------------------------------------------
// psptab_pkg
// Widths, codes, table entry type and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package psptab_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int CW          = $clog2(TABLE_DEPTH + 1);

	localparam int ID_W   = 22;
	localparam int SEC_W  = 32;
	localparam int NSEC_W = 30;
	localparam int PER_W  = SEC_W + NSEC_W;
	localparam int PRIO_W = 7;
	localparam int STAT_W = 2;

	localparam logic [PRIO_W-1:0] TOP_PRIO_RST = 7'd80;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_LISTED    = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// one table entry: id plus period (sec above nsec)
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PER_W-1:0] per;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    idx_last;
		logic    idx_clr;
		logic    idx_inc;
		logic    idx_dec;
		logic    pos_next;
		logic    pos_clr;
		logic    wr_up;
		logic    wr_dn;
		logic    wr_new;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    found_set;
		logic    emit_entry;
		logic    emit_single;
		status_t code;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_remove;
		logic count_zero;
		logic count_full;
		logic idx_zero;
		logic idx_end;
		logic per_less;
		logic hit;
		logic found;
		logic out_free;
	} dp_sts_t;

endpackage

[hdl/psptab_if.sv]
// ----------------------------------------------------------------------------
// psptab request and result channels
// Valid/ready channels carrying one operation item and one result item.
// ----------------------------------------------------------------------------
interface psptab_req_if import psptab_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [ID_W-1:0]   task_id;
	logic [SEC_W-1:0]  period_sec;
	logic [NSEC_W-1:0] period_nsec;

	modport source (output valid, mode, task_id, period_sec, period_nsec, input ready);
	modport sink   (input valid, mode, task_id, period_sec, period_nsec, output ready);
endinterface

interface psptab_rsp_if import psptab_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [ID_W-1:0]   entry_id;
	logic [PRIO_W-1:0] priority_res;
	logic              last;

	modport source (output valid, status, entry_id, priority_res, last, input ready);
	modport sink   (input valid, status, entry_id, priority_res, last, output ready);
endinterface

[hdl/psptab_ctrl.sv]
// ----------------------------------------------------------------------------
// psptab_ctrl
// Sequencer for insert scan, remove scan, listing and error results.
// ----------------------------------------------------------------------------
module psptab_ctrl import psptab_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    idle,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_INS_RD,
		S_INS_EV,
		S_INS_WR,
		S_REM_RD,
		S_REM_EV,
		S_LST_START,
		S_LST_RD,
		S_LST_EV,
		S_ERR
	} state_t;

	state_t  state_q, state_d;
	status_t err_q, err_d;

	assign idle = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		err_d   = err_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.is_remove) begin
					if (sts.count_zero) begin
						err_d   = ST_EMPTY;
						state_d = S_ERR;
					end else begin
						cmd.idx_clr = 1'b1;
						state_d     = S_REM_RD;
					end
				end else if (sts.count_full) begin
					err_d   = ST_FULL;
					state_d = S_ERR;
				end else if (sts.count_zero) begin
					cmd.pos_clr = 1'b1;
					state_d     = S_INS_WR;
				end else begin
					// scan from the tail, shifting longer periods down
					cmd.idx_last = 1'b1;
					state_d      = S_INS_RD;
				end
			end
			S_INS_RD: state_d = S_INS_EV;
			S_INS_EV: begin
				if (sts.per_less) begin
					cmd.wr_up = 1'b1;
					if (sts.idx_zero) begin
						cmd.pos_clr = 1'b1;
						state_d     = S_INS_WR;
					end else begin
						cmd.idx_dec = 1'b1;
						state_d     = S_INS_RD;
					end
				end else begin
					cmd.pos_next = 1'b1;
					state_d      = S_INS_WR;
				end
			end
			S_INS_WR: begin
				cmd.wr_new  = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d     = S_LST_START;
			end
			S_REM_RD: state_d = S_REM_EV;
			S_REM_EV: begin
				// after the match every entry moves up by one
				if (sts.found) begin
					cmd.wr_dn = 1'b1;
				end else if (sts.hit) begin
					cmd.found_set = 1'b1;
				end
				if (sts.idx_end) begin
					if (sts.hit) begin
						cmd.cnt_dec = 1'b1;
						state_d     = S_LST_START;
					end else begin
						err_d   = ST_NOT_FOUND;
						state_d = S_ERR;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_REM_RD;
				end
			end
			S_LST_START: begin
				if (sts.count_zero) begin
					err_d   = ST_EMPTY;
					state_d = S_ERR;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = S_LST_RD;
				end
			end
			S_LST_RD: state_d = S_LST_EV;
			S_LST_EV: begin
				if (sts.out_free) begin
					cmd.emit_entry = 1'b1;
					if (sts.idx_end) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_LST_RD;
					end
				end
			end
			S_ERR: begin
				cmd.code = err_q;
				if (sts.out_free) begin
					cmd.emit_single = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and held error code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q   <= ST_EMPTY;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
		end
	end

endmodule

[hdl/psptab_dp.sv]
// ----------------------------------------------------------------------------
// psptab_dp
// Table memory, entry count, scan index, priority tracking and result register.
// ----------------------------------------------------------------------------
module psptab_dp import psptab_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	input  logic              in_mode,
	input  logic [ID_W-1:0]   in_id,
	input  logic [SEC_W-1:0]  in_sec,
	input  logic [NSEC_W-1:0] in_nsec,
	input  logic              cfg_we,
	input  logic [PRIO_W-1:0] cfg_wdata,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [STAT_W-1:0] out_status,
	output logic [ID_W-1:0]   out_id,
	output logic [PRIO_W-1:0] out_prio,
	output logic              out_last
);

	entry_t            mem_q [TABLE_DEPTH];
	entry_t            rd_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     pos_q;
	logic              mode_q;
	logic [ID_W-1:0]   id_q;
	logic [PER_W-1:0]  per_q;
	logic              found_q;
	logic [PRIO_W-1:0] top_q;
	logic [PRIO_W-1:0] prio_q;
	logic [PER_W-1:0]  prev_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic [PRIO_W-1:0] out_prio_q;
	logic              out_last_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;
	logic [PRIO_W-1:0] prio_next;

	// status back to the controller
	always_comb begin
		sts.is_remove  = (mode_q == MODE_REMOVE);
		sts.count_zero = (count_q == '0);
		sts.count_full = (count_q == CW'(TABLE_DEPTH));
		sts.idx_zero   = (idx_q == '0);
		sts.idx_end    = (CW'(idx_q) == (count_q - CW'(1)));
		sts.per_less   = (per_q < rd_q.per);
		sts.hit        = found_q | (rd_q.id == id_q);
		sts.found      = found_q;
		sts.out_free   = !out_valid_q || out_ready;
	end

	// write port select: shift down, shift up or new entry
	always_comb begin
		wr_en   = cmd.wr_up | cmd.wr_dn | cmd.wr_new;
		wr_addr = pos_q;
		wr_data = '{id: id_q, per: per_q};
		if (cmd.wr_up) begin
			wr_addr = idx_q + AW'(1);
			wr_data = rd_q;
		end else if (cmd.wr_dn) begin
			wr_addr = idx_q - AW'(1);
			wr_data = rd_q;
		end
	end

	// rate-monotonic priority of the entry being listed
	always_comb begin
		if (idx_q == '0) begin
			prio_next = top_q;
		end else if ((prev_q < rd_q.per) && (prio_q > PRIO_W'(1))) begin
			prio_next = prio_q - PRIO_W'(1);
		end else begin
			prio_next = prio_q;
		end
	end

	// table memory, registered read at the scan index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[idx_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			top_q       <= TOP_PRIO_RST;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				top_q <= cfg_wdata;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.capture) begin
				found_q <= 1'b0;
			end else if (cmd.found_set) begin
				found_q <= 1'b1;
			end
			if (cmd.emit_entry || cmd.emit_single) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// operand, index and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			id_q   <= in_id;
			per_q  <= {in_sec, in_nsec};
		end
		if (cmd.idx_last) begin
			idx_q <= AW'(count_q - CW'(1));
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - AW'(1);
		end
		if (cmd.pos_clr) begin
			pos_q <= '0;
		end else if (cmd.pos_next) begin
			pos_q <= idx_q + AW'(1);
		end
		if (cmd.emit_entry) begin
			prio_q       <= prio_next;
			prev_q       <= rd_q.per;
			out_status_q <= ST_LISTED;
			out_id_q     <= rd_q.id;
			out_prio_q   <= prio_next;
			out_last_q   <= sts.idx_end;
		end else if (cmd.emit_single) begin
			out_status_q <= cmd.code;
			out_id_q     <= '0;
			out_prio_q   <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_prio   = out_prio_q;
	assign out_last   = out_last_q;

endmodule

[hdl/period_sorted_priority_table.sv]
// ----------------------------------------------------------------------------
// period_sorted_priority_table
// Period-sorted task table with rate-monotonic priority listing.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   valid/ready        mode, task_id, period_sec, period_nsec
//  rsp      out  valid/ready        status, entry_id, priority_res, last
//  cfg      in   cfg_we (no ready)  cfg_wdata = top_priority
//
//  One operation at a time. The table memory has a registered read, so every
//  entry visit takes a read state and an evaluate state: an insert visits the
//  entries from the tail down to its slot, while a remove and the listing
//  each visit every entry.
//  Reset clears the entry count and loads top_priority with 80; no clearing pass.
//  A stalled rsp holds the listing; req is taken again once the last item of
//  an operation sits in the result register.
// ----------------------------------------------------------------------------
`include "period_sorted_priority_table_assert.svh"

module period_sorted_priority_table import psptab_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	psptab_req_if.sink        req,
	psptab_rsp_if.source      rsp,
	input  logic              cfg_we,
	input  logic [PRIO_W-1:0] cfg_wdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    idle;
	logic    start;

	assign req.ready = idle;
	assign start     = req.valid && idle;

	// sequencer
	psptab_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.idle   (idle),
		.sts    (sts),
		.cmd    (cmd)
	);

	// table and result register
	psptab_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_mode    (req.mode),
		.in_id      (req.task_id),
		.in_sec     (req.period_sec),
		.in_nsec    (req.period_nsec),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_status (rsp.status),
		.out_id     (rsp.entry_id),
		.out_prio   (rsp.priority_res),
		.out_last   (rsp.last)
	);

	// checks
	`PSP_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "took item while busy")
	`PSP_ASSERT_IMPL(a_error_single, rsp.valid && (rsp.status != ST_LISTED), rsp.last && (rsp.entry_id == '0) && (rsp.priority_res == '0), "error result malformed")
	`PSP_ASSERT_IMPL(a_no_overfill, cmd.cnt_inc, !sts.count_full, "insert into full table")

endmodule

[tb/sv/period_sorted_priority_table_tb.sv]
// ----------------------------------------------------------------------------
// period_sorted_priority_table_tb
// Sends insert and remove operations into the task table and checks every
// result item against a behavioral copy of the sorted table or a typed row.
// It starts with a short directed list, then random phases, one per top priority.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module period_sorted_priority_table_tb;
	import psptab_pkg::*;

	localparam int unsigned WATCHDOG_NS = 15_000_000;
	localparam int DRAIN_LIMIT = 60_000;
	localparam int PHASE_OPS   = 76;
	localparam int CALM_OPS    = 40;
	localparam int N_PHASES    = 5;

	typedef struct packed {
		logic              mode;
		logic [ID_W-1:0]   id;
		logic [SEC_W-1:0]  sec;
		logic [NSEC_W-1:0] nsec;
	} op_t;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic              last;
	} rsp_item_t;

	typedef struct packed {
		op_t       op;
		logic      typed;
		rsp_item_t typed_rsp;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [PRIO_W-1:0] cfg_wdata;

	psptab_req_if req_if();
	psptab_rsp_if rsp_if();

	// the config port has a single register (index 0), so no index pin
	period_sorted_priority_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// behavioral copy of the task table
	logic [ID_W-1:0]   tbl_id  [TABLE_DEPTH];
	logic [PER_W-1:0]  tbl_per [TABLE_DEPTH];
	int                tbl_count;
	logic [PRIO_W-1:0] top_prio;

	rsp_item_t op_rsp_q[$];   // listing caused by the latest operation
	rsp_item_t awaited_q[$];  // result items still to come from the block
	dir_row_t  dir_rows[$];
	rsp_item_t want;

	int err_count, n_ops, n_inserts, n_removes, n_checked;
	int n_full, n_empty, n_missing, peak_count;
	bit idle_on;

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= 40)
			$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	function automatic rsp_item_t single_rsp(input status_t st);
		rsp_item_t r;
		r.status = st;
		r.id     = '0;
		r.prio   = '0;
		r.last   = 1'b1;
		return r;
	endfunction

	// rate-monotonic listing: drop one level, not below 1, on each strictly longer period
	task automatic list_table();
		logic [PRIO_W-1:0] prio;
		rsp_item_t r;
		prio = top_prio;
		if (tbl_count == 0) begin
			op_rsp_q.push_back(single_rsp(ST_EMPTY));
		end else begin
			for (int i = 0; i < tbl_count; i++) begin
				if (i > 0 && tbl_per[i-1] < tbl_per[i] && prio > 1)
					prio--;
				r.status = ST_LISTED;
				r.id     = tbl_id[i];
				r.prio   = prio;
				r.last   = (i == tbl_count - 1);
				op_rsp_q.push_back(r);
			end
		end
	endtask

	task automatic apply_table_op(input op_t op);
		logic [PER_W-1:0] per;
		int pos;
		per = {op.sec, op.nsec};
		op_rsp_q.delete();
		pos = tbl_count;
		if (op.mode == MODE_INSERT) begin
			if (tbl_count >= TABLE_DEPTH) begin
				op_rsp_q.push_back(single_rsp(ST_FULL));
			end else begin
				// lands after every entry of equal or shorter period
				for (int i = tbl_count - 1; i >= 0; i--)
					if (per < tbl_per[i])
						pos = i;
				for (int i = tbl_count; i > pos; i--) begin
					tbl_id[i]  = tbl_id[i-1];
					tbl_per[i] = tbl_per[i-1];
				end
				tbl_id[pos]  = op.id;
				tbl_per[pos] = per;
				tbl_count++;
				list_table();
			end
		end else if (tbl_count == 0) begin
			op_rsp_q.push_back(single_rsp(ST_EMPTY));
		end else begin
			// first matching id in table order
			for (int i = tbl_count - 1; i >= 0; i--)
				if (tbl_id[i] == op.id)
					pos = i;
			if (pos == tbl_count) begin
				op_rsp_q.push_back(single_rsp(ST_NOT_FOUND));
			end else begin
				for (int i = pos + 1; i < tbl_count; i++) begin
					tbl_id[i-1]  = tbl_id[i];
					tbl_per[i-1] = tbl_per[i];
				end
				tbl_count--;
				list_table();
			end
		end
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_op(input op_t op, input logic typed, input rsp_item_t typed_rsp);
		req_if.valid       <= 1'b1;
		req_if.mode        <= op.mode;
		req_if.task_id     <= op.id;
		req_if.period_sec  <= op.sec;
		req_if.period_nsec <= op.nsec;
		do @(posedge clk); while (!req_if.ready);
		apply_table_op(op);
		n_ops++;
		if (op.mode == MODE_INSERT)
			n_inserts++;
		else
			n_removes++;
		if (tbl_count > peak_count)
			peak_count = tbl_count;
		case (op_rsp_q[0].status)
			ST_FULL:      n_full++;
			ST_EMPTY:     n_empty++;
			ST_NOT_FOUND: n_missing++;
			default: ;
		endcase
		if (typed)
			awaited_q.push_back(typed_rsp);
		else
			foreach (op_rsp_q[i])
				awaited_q.push_back(op_rsp_q[i]);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 99) < 20) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
	endtask

	// only written with the block idle: every awaited item has come back
	task automatic write_top_prio(input logic [PRIO_W-1:0] value);
		req_if.valid <= 1'b0;
		while (awaited_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		top_prio = value;
	endtask

	task automatic add_row(input logic mode, input int unsigned id,
			input logic [SEC_W-1:0] sec, input logic [NSEC_W-1:0] nsec,
			input logic typed, input status_t st, input int unsigned tid,
			input int unsigned tprio);
		dir_row_t row;
		row.op.mode          = mode;
		row.op.id            = ID_W'(id);
		row.op.sec           = sec;
		row.op.nsec          = nsec;
		row.typed            = typed;
		row.typed_rsp.status = st;
		row.typed_rsp.id     = ID_W'(tid);
		row.typed_rsp.prio   = PRIO_W'(tprio);
		row.typed_rsp.last   = 1'b1;
		dir_rows.push_back(row);
	endtask

	function automatic op_t random_op(input int ins_pct);
		op_t op;
		int pick;
		op.mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
		op.id   = ($urandom_range(0, 99) < 60) ? ID_W'($urandom_range(0, 15))
			: ID_W'($urandom);
		op.sec  = $urandom;
		op.nsec = NSEC_W'($urandom);
		pick = $urandom_range(0, 3);
		if (pick < 2) begin
			// a handful of distinct periods so that ties are common
			op.sec = $urandom_range(0, 3);
			case ($urandom_range(0, 2))
				0:       op.nsec = NSEC_W'(0);
				1:       op.nsec = NSEC_W'(500_000_000);
				default: op.nsec = NSEC_W'(999_999_999);
			endcase
		end else if (pick == 2) begin
			op.nsec = NSEC_W'($urandom_range(0, 999_999_999));
		end
		// removes mostly hit a live entry
		if (op.mode == MODE_REMOVE && tbl_count > 0 && $urandom_range(0, 99) < 85)
			op.id = tbl_id[$urandom_range(0, tbl_count - 1)];
		return op;
	endfunction

	// result sink: random stall bursts
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && stall_left == 0 && $urandom_range(0, 99) < 6)
				stall_left = $urandom_range(1, 19);
			if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			n_checked++;
			if (awaited_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item status %0d id %0h prio %0d",
					rsp_if.status, rsp_if.entry_id, rsp_if.priority_res));
			end else begin
				want = awaited_q.pop_front();
				if (rsp_if.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						rsp_if.status, want.status));
				if (rsp_if.entry_id !== want.id)
					report_mismatch($sformatf("entry_id got %0h want %0h",
						rsp_if.entry_id, want.id));
				if (rsp_if.priority_res !== want.prio)
					report_mismatch($sformatf("priority_res got %0d want %0d",
						rsp_if.priority_res, want.prio));
				if (rsp_if.last !== want.last)
					report_mismatch($sformatf("last got %0b want %0b",
						rsp_if.last, want.last));
			end
		end
	end

	initial begin
		#(WATCHDOG_NS);
		$display("[%0t] watchdog expired, %0d items outstanding", $time, awaited_q.size());
		$display("period_sorted_priority_table verification failed");
		$finish;
	end

	// stimulus
	initial begin
		logic [PRIO_W-1:0] phase_prio [N_PHASES];
		int phase_ins [N_PHASES];
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_if.valid       = 1'b0;
		req_if.mode        = MODE_INSERT;
		req_if.task_id     = '0;
		req_if.period_sec  = '0;
		req_if.period_nsec = '0;
		tbl_count          = 0;
		top_prio           = TOP_PRIO_RST;
		idle_on            = 1'b1;
		phase_prio = '{7'd127, 7'd0, 7'd1, 7'd99, 7'd5};
		phase_ins  = '{75, 75, 20, 80, 25};

		// directed list, runs at the reset priority of 80
		//      mode         id         sec           nsec          typed status       id    prio
		add_row(MODE_REMOVE, 5,         0,            0,            1, ST_EMPTY,     0,    0);
		add_row(MODE_INSERT, 'h3FFFFF,  0,            0,            1, ST_LISTED,    'h3FFFFF, 80);
		add_row(MODE_REMOVE, 'h3FFFFF,  0,            0,            1, ST_EMPTY,     0,    0);
		add_row(MODE_INSERT, 0,         32'hFFFFFFFF, 30'h3FFFFFFF, 1, ST_LISTED,    0,    80);
		add_row(MODE_INSERT, 1,         0,            0,            0, ST_LISTED,    0,    0);
		add_row(MODE_INSERT, 2,         0,            0,            0, ST_LISTED,    0,    0);
		add_row(MODE_INSERT, 3,         0,            999_999_999,  0, ST_LISTED,    0,    0);
		add_row(MODE_INSERT, 4,         1,            0,            0, ST_LISTED,    0,    0);
		// nanoseconds past one second compare as raw bits
		add_row(MODE_INSERT, 5,         0,            1_000_000_000, 0, ST_LISTED,   0,    0);
		add_row(MODE_INSERT, 2,         0,            30'h2AAAAAAA, 0, ST_LISTED,    0,    0);
		add_row(MODE_INSERT, 'h155555,  32'hAAAAAAAA, 30'h15555555, 0, ST_LISTED,    0,    0);
		add_row(MODE_INSERT, 'h2AAAAA,  32'h55555555, 30'h2AAAAAAA, 0, ST_LISTED,    0,    0);
		// duplicate id: the first one goes
		add_row(MODE_REMOVE, 2,         0,            0,            0, ST_LISTED,    0,    0);
		add_row(MODE_REMOVE, 'h123456,  0,            0,            1, ST_NOT_FOUND, 0,    0);
		add_row(MODE_REMOVE, 2,         0,            0,            0, ST_LISTED,    0,    0);
		add_row(MODE_INSERT, 7,         32'hFFFFFFFF, 30'h3FFFFFFF, 0, ST_LISTED,    0,    0);
		add_row(MODE_REMOVE, 0,         0,            0,            0, ST_LISTED,    0,    0);
		add_row(MODE_REMOVE, 1,         0,            0,            0, ST_LISTED,    0,    0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			sender_gap();
			send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].typed_rsp);
		end

		// random phases: a high insert bias fills the table, a low one drains it
		for (int p = 0; p < N_PHASES; p++) begin
			write_top_prio(phase_prio[p]);
			for (int k = 0; k < PHASE_OPS; k++) begin
				if (p == N_PHASES - 1 && k == PHASE_OPS - CALM_OPS)
					idle_on = 1'b0;
				sender_gap();
				send_op(random_op(phase_ins[p]), 1'b0, '0);
			end
		end
		req_if.valid <= 1'b0;

		for (int w = 0; w < DRAIN_LIMIT && awaited_q.size() != 0; w++)
			@(posedge clk);
		if (awaited_q.size() != 0)
			report_mismatch($sformatf("%0d result items never arrived", awaited_q.size()));
		repeat (16) @(posedge clk);

		$display("Covered %0d operations (%0d inserts, %0d removes), %0d result items checked",
			n_ops, n_inserts, n_removes, n_checked);
		$display("Full %0d, empty %0d, id not found %0d, peak depth %0d, mismatches %0d",
			n_full, n_empty, n_missing, peak_count, err_count);
		if (err_count == 0)
			$display("period_sorted_priority_table verification clean");
		else
			$display("period_sorted_priority_table verification failed");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/psptab_pkg.sv
hdl/psptab_if.sv
hdl/psptab_ctrl.sv
hdl/psptab_dp.sv
hdl/period_sorted_priority_table.sv
tb/sv/period_sorted_priority_table_tb.sv
